// File: rtl/rpdc_pkg.sv
// -----------------------------------------------------------------------------
// rpdc_pkg - shared types and constants for ray-to-planar depth correction
// Field widths, fixed-point formats, pipeline sizes and register codes.
// -----------------------------------------------------------------------------
package rpdc_pkg;

	localparam int DEPTH_W     = 16;
	localparam int PIX_W       = 12;
	localparam int WIDTH_W     = 13;
	localparam int CENTER_W    = 16;
	localparam int INVF_W      = 24;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int DATA_W      = DEPTH_W + 2 * PIX_W;
	localparam int MAX_DIM     = 4096;

	localparam int SUBPIX_W    = 4;
	localparam int MAG_W       = CENTER_W;
	localparam int CPROD_W     = MAG_W + INVF_W;
	localparam int COORD_SH    = 12;
	localparam int COORD_W     = CPROD_W - COORD_SH;
	localparam int SQ_W        = 2 * COORD_W;
	localparam int RAD_W       = SQ_W + 2;
	localparam int ROOT_W      = RAD_W / 2;
	localparam int SQRT_STEPS  = ROOT_W;
	localparam int SREM_W      = ROOT_W + 3;
	localparam int FRAC_W      = 16;
	localparam int NORM_FRAC_W = 24;
	localparam int NORM_W      = NORM_FRAC_W + 1;
	localparam int DIV_STEPS   = NORM_W;
	localparam int NUM_W       = NORM_FRAC_W + FRAC_W + 1;
	localparam int DREM_W      = ROOT_W + 1;
	localparam int DPROD_W     = DEPTH_W + NORM_W;

	localparam logic [CPROD_W-1:0] COORD_HALF = CPROD_W'(1) << (COORD_SH - 1);
	localparam logic [RAD_W-1:0]   RAD_ONE    = RAD_W'(1) << (2 * FRAC_W);
	localparam logic [NORM_W-1:0]  NORM_ONE   = NORM_W'(1) << NORM_FRAC_W;
	localparam logic [DPROD_W-1:0] DEPTH_HALF = DPROD_W'(1) << (NORM_FRAC_W - 1);

	localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH = 13'd640;
	localparam logic [CENTER_W-1:0] RST_CENTER_X    = 16'd5120;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 16'd3840;
	localparam logic [INVF_W-1:0]   RST_INV_FOCAL_X = 24'd31457;
	localparam logic [INVF_W-1:0]   RST_INV_FOCAL_Y = 24'd31457;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH = 3'd0,
		REG_CENTER_X    = 3'd1,
		REG_CENTER_Y    = 3'd2,
		REG_INV_FOCAL_X = 3'd3,
		REG_INV_FOCAL_Y = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [PIX_W-1:0]   row;
		logic [PIX_W-1:0]   mcol;
	} side_t;

endpackage

// File: rtl/rpdc_sqrt.sv
// -----------------------------------------------------------------------------
// rpdc_sqrt - pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// -----------------------------------------------------------------------------
module rpdc_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        rad_valid,
	input  rpdc_pkg::side_t             rad_side,
	input  logic [rpdc_pkg::RAD_W-1:0]  rad,
	output logic                        root_valid,
	output rpdc_pkg::side_t             root_side,
	output logic [rpdc_pkg::ROOT_W-1:0] root
);
	import rpdc_pkg::*;

	logic              vld_s  [SQRT_STEPS];
	side_t             side_s [SQRT_STEPS];
	logic [RAD_W-1:0]  rad_s  [SQRT_STEPS];
	logic [SREM_W-1:0] rem_s  [SQRT_STEPS];
	logic [ROOT_W-1:0] root_s [SQRT_STEPS];

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		localparam int K = SQRT_STEPS - 1 - i;
		logic              vld_c;
		side_t             side_c;
		logic [RAD_W-1:0]  rad_c;
		logic [SREM_W-1:0] rem_c;
		logic [ROOT_W-1:0] root_c;
		logic [SREM_W-1:0] shift_c;
		logic [SREM_W-1:0] trial_c;
		logic              ge_c;

		if (i == 0) begin : g_first
			assign vld_c  = rad_valid;
			assign side_c = rad_side;
			assign rad_c  = rad;
			assign rem_c  = '0;
			assign root_c = '0;
		end else begin : g_next
			assign vld_c  = vld_s[i-1];
			assign side_c = side_s[i-1];
			assign rad_c  = rad_s[i-1];
			assign rem_c  = rem_s[i-1];
			assign root_c = root_s[i-1];
		end

		assign shift_c = {rem_c[SREM_W-3:0], rad_c[2*K+1 -: 2]};
		assign trial_c = {1'b0, root_c, 2'b01};
		assign ge_c    = shift_c >= trial_c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= side_c;
				rad_s[i]  <= rad_c;
				rem_s[i]  <= ge_c ? shift_c - trial_c : shift_c;
				root_s[i] <= {root_c[ROOT_W-2:0], ge_c};
			end
		end
	end

	assign root_valid = vld_s[SQRT_STEPS-1];
	assign root_side  = side_s[SQRT_STEPS-1];
	assign root       = root_s[SQRT_STEPS-1];

`ifndef SYNTHESIS
	a_root_min: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid |-> root[ROOT_W-1:FRAC_W] != '0)
		else $error("root below one");
`endif

endmodule

// File: rtl/rpdc_div.sv
// -----------------------------------------------------------------------------
// rpdc_div - pipelined reciprocal of the root
// Rounded 2^40 / root by restoring division, one quotient bit per stage.
// -----------------------------------------------------------------------------
module rpdc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        root_valid,
	input  rpdc_pkg::side_t             root_side,
	input  logic [rpdc_pkg::ROOT_W-1:0] root,
	output logic                        norm_valid,
	output rpdc_pkg::side_t             norm_side,
	output logic [rpdc_pkg::NORM_W-1:0] norm
);
	import rpdc_pkg::*;

	logic              vld_s  [DIV_STEPS];
	side_t             side_s [DIV_STEPS];
	logic [NUM_W-1:0]  num_s  [DIV_STEPS];
	logic [ROOT_W-1:0] dvs_s  [DIV_STEPS];
	logic [DREM_W-1:0] rem_s  [DIV_STEPS];
	logic [NORM_W-1:0] quo_s  [DIV_STEPS];

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		localparam int J = DIV_STEPS - 1 - i;
		logic              vld_c;
		side_t             side_c;
		logic [NUM_W-1:0]  num_c;
		logic [ROOT_W-1:0] dvs_c;
		logic [DREM_W-1:0] rem_c;
		logic [NORM_W-1:0] quo_c;
		logic [DREM_W-1:0] shift_c;
		logic [DREM_W-1:0] dext_c;
		logic              ge_c;

		if (i == 0) begin : g_first
			assign vld_c  = root_valid;
			assign side_c = root_side;
			assign dvs_c  = root;
			assign num_c  = {1'b1, {(NUM_W-ROOT_W){1'b0}}, root[ROOT_W-1:1]};
			assign rem_c  = {{(DREM_W-(NUM_W-DIV_STEPS)){1'b0}}, num_c[NUM_W-1:DIV_STEPS]};
			assign quo_c  = '0;
		end else begin : g_next
			assign vld_c  = vld_s[i-1];
			assign side_c = side_s[i-1];
			assign dvs_c  = dvs_s[i-1];
			assign num_c  = num_s[i-1];
			assign rem_c  = rem_s[i-1];
			assign quo_c  = quo_s[i-1];
		end

		assign shift_c = {rem_c[DREM_W-2:0], num_c[J]};
		assign dext_c  = {1'b0, dvs_c};
		assign ge_c    = shift_c >= dext_c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= side_c;
				num_s[i]  <= num_c;
				dvs_s[i]  <= dvs_c;
				rem_s[i]  <= ge_c ? shift_c - dext_c : shift_c;
				quo_s[i]  <= {quo_c[NORM_W-2:0], ge_c};
			end
		end
	end

	assign norm_valid = vld_s[DIV_STEPS-1];
	assign norm_side  = side_s[DIV_STEPS-1];
	assign norm       = quo_s[DIV_STEPS-1];

`ifndef SYNTHESIS
	a_norm_max: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid |-> norm <= NORM_ONE)
		else $error("norm factor above one");
`endif

endmodule

// File: rtl/ray_to_planar_depth_correction_core.sv
// -----------------------------------------------------------------------------
// ray_to_planar_depth_correction_core - range to planar depth, pinhole model
// Scales ray depth by 1/sqrt(x*x + y*y + 1) and mirrors the column.
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+--------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | ray_depth, pixel_row, pixel_col
//  m_axis   | out | m_axis_tvalid / m_axis_tready | planar_depth, out_row, mirrored_col
//  cfg      | in  | cfg_we                        | cfg_idx, cfg_data
//
//  One pixel per cycle while the output is not stalled; 5 front stages, 29 square root
//  stages, 25 divider stages, a multiply stage and the output register.
//  Reset clears the valid bits and loads the default camera registers.
//  A stalled output holds every stage; no transfer is lost or repeated.
// -----------------------------------------------------------------------------
module ray_to_planar_depth_correction_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// ray_depth[15:0], pixel_row[27:16], pixel_col[39:28]
	input  logic [rpdc_pkg::DATA_W-1:0]     s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// planar_depth[15:0], out_row[27:16], mirrored_col[39:28]
	output logic [rpdc_pkg::DATA_W-1:0]     m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [rpdc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rpdc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rpdc_pkg::*;

	logic [WIDTH_W-1:0]  image_width_q;
	logic [CENTER_W-1:0] center_x_q;
	logic [CENTER_W-1:0] center_y_q;
	logic [INVF_W-1:0]   inv_focal_x_q;
	logic [INVF_W-1:0]   inv_focal_y_q;

	logic                en;
	logic [DEPTH_W-1:0]  in_depth;
	logic [PIX_W-1:0]    in_row;
	logic [PIX_W-1:0]    in_col;
	logic [MAG_W-1:0]    px_c;
	logic [MAG_W-1:0]    py_c;
	logic [WIDTH_W-1:0]  w_eff_c;
	side_t               side_c;

	logic                valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                valid_s6, valid_s7;
	side_t               side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [MAG_W-1:0]    mag_x_s1, mag_y_s1;
	logic [CPROD_W-1:0]  prod_x_s2, prod_y_s2;
	logic [COORD_W-1:0]  xq_s3, yq_s3;
	logic [SQ_W-1:0]     xsq_s4, ysq_s4;
	logic [RAD_W-1:0]    rad_s5;
	logic [DPROD_W-1:0]  prod_s6;
	logic [DPROD_W-1:0]  round_c;
	logic [DEPTH_W-1:0]  planar_s7;
	logic [PIX_W-1:0]    row_s7, mcol_s7;

	logic                root_valid;
	side_t               root_side;
	logic [ROOT_W-1:0]   root;
	logic                norm_valid;
	side_t               norm_side;
	logic [NORM_W-1:0]   norm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= RST_IMAGE_WIDTH;
			center_x_q    <= RST_CENTER_X;
			center_y_q    <= RST_CENTER_Y;
			inv_focal_x_q <= RST_INV_FOCAL_X;
			inv_focal_y_q <= RST_INV_FOCAL_Y;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH: image_width_q <= cfg_data[WIDTH_W-1:0];
				REG_CENTER_X:    center_x_q    <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y:    center_y_q    <= cfg_data[CENTER_W-1:0];
				REG_INV_FOCAL_X: inv_focal_x_q <= cfg_data[INVF_W-1:0];
				REG_INV_FOCAL_Y: inv_focal_y_q <= cfg_data[INVF_W-1:0];
				default: ;
			endcase
		end
	end

	assign en            = !valid_s7 || m_axis_tready;
	assign s_axis_tready = en;

	assign in_depth = s_axis_tdata[DEPTH_W-1:0];
	assign in_row   = s_axis_tdata[DEPTH_W+PIX_W-1:DEPTH_W];
	assign in_col   = s_axis_tdata[DATA_W-1:DEPTH_W+PIX_W];
	assign px_c     = {in_col, {SUBPIX_W{1'b0}}};
	assign py_c     = {in_row, {SUBPIX_W{1'b0}}};
	assign w_eff_c  = (image_width_q > WIDTH_W'(MAX_DIM)) ? WIDTH_W'(MAX_DIM) : image_width_q;

	always_comb begin
		side_c.depth = in_depth;
		side_c.row   = in_row;
		side_c.mcol  = w_eff_c[PIX_W-1:0] - PIX_W'(1) - in_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= norm_valid;
			valid_s7 <= valid_s6;
		end
	end

	assign round_c = prod_s6 + DEPTH_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= side_c;
			mag_x_s1  <= (px_c >= center_x_q) ? px_c - center_x_q : center_x_q - px_c;
			mag_y_s1  <= (py_c >= center_y_q) ? py_c - center_y_q : center_y_q - py_c;
			side_s2   <= side_s1;
			prod_x_s2 <= CPROD_W'(mag_x_s1) * CPROD_W'(inv_focal_x_q);
			prod_y_s2 <= CPROD_W'(mag_y_s1) * CPROD_W'(inv_focal_y_q);
			side_s3   <= side_s2;
			xq_s3     <= prod_x_s2[CPROD_W-1:COORD_SH] + COORD_W'(prod_x_s2[COORD_SH-1]);
			yq_s3     <= prod_y_s2[CPROD_W-1:COORD_SH] + COORD_W'(prod_y_s2[COORD_SH-1]);
			side_s4   <= side_s3;
			xsq_s4    <= SQ_W'(xq_s3) * SQ_W'(xq_s3);
			ysq_s4    <= SQ_W'(yq_s3) * SQ_W'(yq_s3);
			side_s5   <= side_s4;
			rad_s5    <= RAD_W'(xsq_s4) + RAD_W'(ysq_s4) + RAD_ONE;
			side_s6   <= norm_side;
			prod_s6   <= DPROD_W'(norm_side.depth) * DPROD_W'(norm);
			planar_s7 <= round_c[DPROD_W-1] ? '1 : round_c[NORM_FRAC_W+DEPTH_W-1:NORM_FRAC_W];
			row_s7    <= side_s6.row;
			mcol_s7   <= side_s6.mcol;
		end
	end

	rpdc_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.rad_valid  (valid_s5),
		.rad_side   (side_s5),
		.rad        (rad_s5),
		.root_valid (root_valid),
		.root_side  (root_side),
		.root       (root)
	);

	rpdc_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.root_valid (root_valid),
		.root_side  (root_side),
		.root       (root),
		.norm_valid (norm_valid),
		.norm_side  (norm_side),
		.norm       (norm)
	);

	assign m_axis_tvalid = valid_s7;
	assign m_axis_tdata  = {mcol_s7, row_s7, planar_s7};

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

	a_s6_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && en |=> m_axis_tvalid)
		else $error("product stage lost a transfer");

	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s1) && $stable(valid_s5))
		else $error("front stages moved during stall");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb - testbench for ray_to_planar_depth_correction_core
// Runs a table of directed pixels and register writes covering the corners of
// the camera registers, then random pixels over several random camera setups
// under varying source gaps and sink back-pressure. Every result transfer is
// checked against a typed expected value or an in-bench fixed-point model of the depth correction.
// -----------------------------------------------------------------------------
module tb;
	import rpdc_pkg::*;

	localparam int LATENCY      = 61;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_PIXELS = 200;

	localparam logic [CFG_IDX_W-1:0] SPARE_REG_A = 3'd5;
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_B = 3'd6;
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_C = 3'd7;

	localparam logic ROW_PIXEL = 1'b0;
	localparam logic ROW_WRITE = 1'b1;
	localparam logic EXP_MODEL = 1'b0;
	localparam logic EXP_TYPED = 1'b1;

	typedef struct packed {
		logic [DEPTH_W-1:0] planar;
		logic [PIX_W-1:0]   row;
		logic [PIX_W-1:0]   mcol;
	} corrected_t;

	typedef struct packed {
		logic                  kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] value;
		logic [DEPTH_W-1:0]    depth;
		logic [PIX_W-1:0]      row;
		logic [PIX_W-1:0]      col;
		logic                  typed;
		corrected_t            expv;
	} step_t;

	localparam int N_DIRECTED = 37;
	localparam step_t DIRECTED [N_DIRECTED] = '{
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd0, 12'd0, 12'd0, EXP_TYPED, '{16'd0, 12'd0, 12'd639}},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd65535, 12'd240, 12'd320, EXP_TYPED,
			'{16'd65535, 12'd240, 12'd319}},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd1, 12'd240, 12'd320, EXP_TYPED,
			'{16'd1, 12'd240, 12'd319}},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd65535, 12'd4095, 12'd4095, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd65535, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd40000, 12'd239, 12'd639, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd30000, 12'd100, 12'd640, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'hAAAA, 12'hAAA, 12'h555, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'h5555, 12'h555, 12'hAAA, EXP_MODEL, '0},
		'{ROW_WRITE, REG_IMAGE_WIDTH, 24'd0, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd1000, 12'd5, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, REG_INV_FOCAL_X, 24'd0, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, REG_INV_FOCAL_Y, 24'd0, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd65535, 12'd4095, 12'd0, EXP_TYPED,
			'{16'd65535, 12'd4095, 12'd4095}},
		'{ROW_WRITE, REG_IMAGE_WIDTH, 24'd8191, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd777, 12'd0, 12'd0, EXP_TYPED, '{16'd777, 12'd0, 12'd4095}},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd777, 12'd9, 12'd4095, EXP_TYPED, '{16'd777, 12'd9, 12'd0}},
		'{ROW_WRITE, REG_IMAGE_WIDTH, 24'd1, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd5, 12'd1, 12'd0, EXP_TYPED, '{16'd5, 12'd1, 12'd0}},
		'{ROW_WRITE, SPARE_REG_A, 24'hFFFFFF, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, SPARE_REG_B, 24'hFFFFFF, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, SPARE_REG_C, 24'hFFFFFF, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd42, 12'd3, 12'd1, EXP_TYPED, '{16'd42, 12'd3, 12'd4095}},
		'{ROW_WRITE, REG_IMAGE_WIDTH, 24'd4096, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, REG_CENTER_X, 24'd0, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, REG_CENTER_Y, 24'd65535, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, REG_INV_FOCAL_X, 24'hFFFFFF, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, REG_INV_FOCAL_Y, 24'hFFFFFF, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd65535, 12'd4095, 12'd4095, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd65535, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd65535, 12'd2048, 12'd2048, EXP_MODEL, '0},
		'{ROW_WRITE, REG_CENTER_X, 24'd65535, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, REG_CENTER_Y, 24'd0, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, REG_INV_FOCAL_X, 24'd1, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_WRITE, REG_INV_FOCAL_Y, 24'd1, 16'd0, 12'd0, 12'd0, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd65535, 12'd0, 12'd4095, EXP_MODEL, '0},
		'{ROW_PIXEL, 3'd0, 24'd0, 16'd65535, 12'd4095, 12'd0, EXP_MODEL, '0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [DATA_W-1:0]     s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [DATA_W-1:0]     m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [WIDTH_W-1:0]  cam_width;
	logic [CENTER_W-1:0] cam_center_x;
	logic [CENTER_W-1:0] cam_center_y;
	logic [INVF_W-1:0]   cam_inv_fx;
	logic [INVF_W-1:0]   cam_inv_fy;

	corrected_t corrected_q [$];
	int         send_idle_pct;
	int         recv_stall_pct;
	int         mismatches;
	int         cycle_count;

	ray_to_planar_depth_correction_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [63:0] axis_coord(input logic [PIX_W-1:0] pix,
			input logic [CENTER_W-1:0] center, input logic [INVF_W-1:0] inv_f);
		logic [63:0] p;
		logic [63:0] mag;
		p = 64'(pix) << SUBPIX_W;
		mag = (p >= 64'(center)) ? p - 64'(center) : 64'(center) - p;
		return (mag * 64'(inv_f) + 64'd2048) >> COORD_SH;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] step;
		rem = v;
		root = '0;
		step = 64'd1 << 62;
		while (step > rem)
			step = step >> 2;
		while (step != 0) begin
			if (rem >= root + step) begin
				rem = rem - (root + step);
				root = (root >> 1) + step;
			end else begin
				root = root >> 1;
			end
			step = step >> 2;
		end
		return root;
	endfunction

	function automatic corrected_t correct_pixel(input logic [DEPTH_W-1:0] depth,
			input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col);
		logic [63:0]        xq;
		logic [63:0]        yq;
		logic [63:0]        root;
		logic [63:0]        norm;
		logic [63:0]        planar;
		logic [WIDTH_W-1:0] w;
		corrected_t         c;
		xq = axis_coord(col, cam_center_x, cam_inv_fx);
		yq = axis_coord(row, cam_center_y, cam_inv_fy);
		root = floor_sqrt(xq * xq + yq * yq + (64'd1 << 32));
		if (root == 0)
			root = 64'd1;
		norm = ((64'd1 << 40) + (root >> 1)) / root;
		planar = (64'(depth) * norm + (64'd1 << 23)) >> 24;
		if (planar > 64'hFFFF)
			planar = 64'hFFFF;
		w = (cam_width > WIDTH_W'(MAX_DIM)) ? WIDTH_W'(MAX_DIM) : cam_width;
		c.planar = planar[DEPTH_W-1:0];
		c.row = row;
		c.mcol = PIX_W'(w - WIDTH_W'(1) - WIDTH_W'(col));
		return c;
	endfunction

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (corrected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = value;
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH: cam_width = value[WIDTH_W-1:0];
			REG_CENTER_X:    cam_center_x = value[CENTER_W-1:0];
			REG_CENTER_Y:    cam_center_y = value[CENTER_W-1:0];
			REG_INV_FOCAL_X: cam_inv_fx = value[INVF_W-1:0];
			REG_INV_FOCAL_Y: cam_inv_fy = value[INVF_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic [PIX_W-1:0] row,
			input logic [PIX_W-1:0] col, input logic typed, input corrected_t expv);
		corrected_t expected;
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {col, row, depth};
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected = typed ? expv : correct_pixel(depth, row, col);
		corrected_q = {corrected_q, expected};
	endtask

	function automatic logic [INVF_W-1:0] random_inv_focal();
		case ($urandom_range(3))
			0: return INVF_W'(32'h0100_0000 / $urandom_range(3000, 60));
			1: return INVF_W'($urandom);
			2: return '0;
			default: return INVF_W'($urandom_range(65535, 1));
		endcase
	endfunction

	task automatic randomize_camera();
		logic [CFG_DATA_W-1:0] w;
		case ($urandom_range(3))
			0: w = CFG_DATA_W'($urandom_range(MAX_DIM, 1));
			1: w = CFG_DATA_W'(RST_IMAGE_WIDTH);
			2: w = CFG_DATA_W'($urandom_range(8191));
			default: w = $urandom_range(1) ? CFG_DATA_W'(MAX_DIM) : CFG_DATA_W'(1);
		endcase
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_CENTER_X, $urandom_range(1) ? CFG_DATA_W'($urandom_range(65535))
			: CFG_DATA_W'($urandom_range(MAX_DIM * 16 - 1)));
		write_reg(REG_CENTER_Y, $urandom_range(1) ? CFG_DATA_W'($urandom_range(65535))
			: CFG_DATA_W'($urandom_range(MAX_DIM * 16 - 1)));
		write_reg(REG_INV_FOCAL_X, random_inv_focal());
		write_reg(REG_INV_FOCAL_Y, random_inv_focal());
		write_reg(CFG_IDX_W'($urandom_range(SPARE_REG_C, SPARE_REG_A)), CFG_DATA_W'($urandom));
	endtask

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready = !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		corrected_t got;
		corrected_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.planar = m_axis_tdata[15:0];
			got.row = m_axis_tdata[27:16];
			got.mcol = m_axis_tdata[39:28];
			if (corrected_q.size() == 0) begin
				$error("unexpected result transfer: tdata %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = corrected_q.pop_front();
				if (got.planar !== want.planar) begin
					$error("planar_depth: expected %0d, got %0d", want.planar, got.planar);
					mismatches++;
				end
				if (got.row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, got.row);
					mismatches++;
				end
				if (got.mcol !== want.mcol) begin
					$error("mirrored_col: expected %0d, got %0d", want.mcol, got.mcol);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [DEPTH_W-1:0] depth;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		cam_width = RST_IMAGE_WIDTH;
		cam_center_x = RST_CENTER_X;
		cam_center_y = RST_CENTER_Y;
		cam_inv_fx = RST_INV_FOCAL_X;
		cam_inv_fy = RST_INV_FOCAL_Y;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(DIRECTED[i].idx, DIRECTED[i].value);
			end else begin
				send_pixel(DIRECTED[i].depth, DIRECTED[i].row, DIRECTED[i].col,
					DIRECTED[i].typed, DIRECTED[i].expv);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_results();
			randomize_camera();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				// hold off the source until the pipeline has emptied
				if (ph == 2 && n == PHASE_PIXELS / 2)
					drain_results();
				if ($urandom_range(7) == 0)
					depth = $urandom_range(1) ? '1 : '0;
				else
					depth = DEPTH_W'($urandom);
				send_pixel(depth, PIX_W'($urandom), PIX_W'($urandom), EXP_MODEL, '0);
			end
		end

		drain_results();
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
